/* hw/rtl/mqlb_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-queue linked buffer package
// Shared sizes, codes, payload types and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mqlb_pkg;

   localparam int NUM_QUEUES   = 16;
   localparam int POOL_ENTRIES = 64;
   localparam int HANDLE_BITS  = 16;

   localparam int ENTRY_BITS = $clog2(POOL_ENTRIES);
   localparam int COUNT_BITS = $clog2(POOL_ENTRIES + 1);
   localparam int QIDX_BITS  = $clog2(NUM_QUEUES);
   localparam int QCNT_BITS  = $clog2(NUM_QUEUES + 1);
   localparam int WALK_BITS  = (COUNT_BITS > QCNT_BITS) ? COUNT_BITS : QCNT_BITS;
   localparam int DATA_BITS  = 4 + HANDLE_BITS;

   localparam logic [2:0] CMD_ENQUEUE   = 3'd0;
   localparam logic [2:0] CMD_DEQUEUE   = 3'd1;
   localparam logic [2:0] CMD_FLUSH     = 3'd2;
   localparam logic [2:0] CMD_PEEK      = 3'd3;
   localparam logic [2:0] CMD_LIST      = 3'd4;
   localparam logic [2:0] CMD_FLUSH_ALL = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [4:0] QUEUE_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [2:0]  command;
      logic [3:0]  queue_index;
      logic [3:0]  sender_id;
      logic [15:0] message_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  out_receiver;
      logic [3:0]  out_sender;
      logic [15:0] out_handle;
      logic        last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_INIT,
      OP_ENQ_RD,
      OP_ENQ_WR,
      OP_ENQ_LINK,
      OP_DEQ_RD,
      OP_DEQ_WR,
      OP_FLUSH,
      OP_FLUSH_ALL,
      OP_LIST_START,
      OP_LIST_NEXT
   } dp_op_type;

   typedef enum logic [1:0] {
      EM_NONE,
      EM_ENQ,
      EM_ENTRY
   } emit_sel_type;

   typedef struct packed {
      dp_op_type    op;
      logic         emit;
      emit_sel_type sel;
      logic [1:0]   status;
      logic         last;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] command;
      logic       q_ok;
      logic       q_empty;
      logic       pool_empty;
      logic       fa_done;
      logic       list_last;
      logic       walk_last;
      logic       rsp_free;
   } dp_stat_type;

endpackage

/* hw/rtl/multi_queue_linked_buffer.sv */
// ----------------------------------------------------------------------------
// Multi-queue linked buffer
// Per-receiver FIFOs kept as linked lists in a shared pool with a free list.
// ----------------------------------------------------------------------------
//  Channel    Ports                           Direction
//  request    req_valid/req_ready/req_data    in
//  response   rsp_valid/rsp_ready/rsp_data    out
//  register   csr_we/csr_wdata (queue_count)  in
//
// List emits one result per entry and flush all walks the queues below the
// queue count register; each step does at most one link write or one link
// read. After reset the link memory is chained into the free list while
// req_ready is held low. The result register lets a new transaction be
// accepted while the previous result is still pending.
// ----------------------------------------------------------------------------
module multi_queue_linked_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mqlb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mqlb_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [4:0]        csr_wdata
);

   mqlb_pkg::ctl_cmd_type cmd;
   mqlb_pkg::dp_stat_type stat;

   mqlb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mqlb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/mqlb_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mqlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/mqlb_datapath.sv */
// ----------------------------------------------------------------------------
// Multi-queue linked buffer datapath
// Pool memories, queue pointers, free list, walk counter and result register.
// ----------------------------------------------------------------------------
module mqlb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mqlb_pkg::req_type     req_data,
   input  logic                  csr_we,
   input  logic [4:0]            csr_wdata,
   input  mqlb_pkg::ctl_cmd_type cmd,
   output mqlb_pkg::dp_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mqlb_pkg::rsp_type     rsp_data
);

   localparam int EB = mqlb_pkg::ENTRY_BITS;
   localparam int CB = mqlb_pkg::COUNT_BITS;
   localparam int QB = mqlb_pkg::QIDX_BITS;
   localparam int WB = mqlb_pkg::WALK_BITS;
   localparam int NQ = mqlb_pkg::NUM_QUEUES;
   localparam int HB = mqlb_pkg::HANDLE_BITS;

   mqlb_pkg::req_type req_ff, req_in;
   logic [4:0]        qcnt_ff, qcnt_in;
   logic [EB-1:0]     head_ff [NQ];
   logic [EB-1:0]     head_in [NQ];
   logic [EB-1:0]     tail_ff [NQ];
   logic [EB-1:0]     tail_in [NQ];
   logic [CB-1:0]     len_ff [NQ];
   logic [CB-1:0]     len_in [NQ];
   logic [EB-1:0]     free_head_ff, free_head_in;
   logic [CB-1:0]     free_cnt_ff, free_cnt_in;
   logic [WB-1:0]     walk_ff, walk_in;
   logic [EB-1:0]     entry_ff, entry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mqlb_pkg::rsp_type rsp_ff, rsp_in;

   logic                           link_we, rd_en, data_we;
   logic [EB-1:0]                  link_waddr, link_wdata, rd_addr;
   logic [EB-1:0]                  link_rd;
   logic [mqlb_pkg::DATA_BITS-1:0] data_wdata, data_rd;

   logic [QB-1:0] qi, fidx;
   logic          q_ok, f_ok;
   logic [CB:0]   cnt_sum;
   int            fa_limit;

   mqlb_ram #(.WIDTH(EB), .DEPTH(mqlb_pkg::POOL_ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   mqlb_ram #(.WIDTH(mqlb_pkg::DATA_BITS), .DEPTH(mqlb_pkg::POOL_ENTRIES)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (free_head_ff),
      .wr_data (data_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (data_rd)
   );

   assign qi       = QB'(req_ff.queue_index);
   assign q_ok     = 32'(req_ff.queue_index) < NQ;
   assign fa_limit = (32'(qcnt_ff) > NQ) ? NQ : 32'(qcnt_ff);
   assign fidx     = (cmd.op == mqlb_pkg::OP_FLUSH_ALL) ? QB'(walk_ff) : qi;
   assign f_ok     = (cmd.op == mqlb_pkg::OP_FLUSH_ALL) ? 1'b1 : q_ok;
   assign cnt_sum  = {1'b0, free_cnt_ff} + {1'b0, len_ff[fidx]};
   assign data_wdata = {req_ff.sender_id, HB'(req_ff.message_handle)};

   always_comb begin
      stat.command    = req_ff.command;
      stat.q_ok       = q_ok;
      stat.q_empty    = !q_ok || (len_ff[qi] == '0);
      stat.pool_empty = (free_cnt_ff == '0);
      stat.fa_done    = 32'(walk_ff) >= fa_limit;
      stat.list_last  = (walk_ff == WB'(1));
      stat.walk_last  = 32'(walk_ff) == mqlb_pkg::POOL_ENTRIES - 1;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      req_in       = req_ff;
      qcnt_in      = csr_we ? csr_wdata : qcnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      len_in       = len_ff;
      free_head_in = free_head_ff;
      free_cnt_in  = free_cnt_ff;
      walk_in      = walk_ff;
      entry_in     = entry_ff;
      link_we      = 1'b0;
      link_waddr   = '0;
      link_wdata   = '0;
      data_we      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      case (cmd.op)
         mqlb_pkg::OP_CAPTURE: begin
            req_in  = req_data;
            walk_in = '0;
         end
         mqlb_pkg::OP_INIT: begin
            link_we    = 1'b1;
            link_waddr = EB'(walk_ff);
            link_wdata = stat.walk_last ? '0 : EB'(walk_ff + WB'(1));
            walk_in    = walk_ff + WB'(1);
         end
         mqlb_pkg::OP_ENQ_RD: begin
            rd_en   = 1'b1;
            rd_addr = free_head_ff;
         end
         mqlb_pkg::OP_ENQ_WR: begin
            link_we      = 1'b1;
            link_waddr   = free_head_ff;
            data_we      = 1'b1;
            free_head_in = link_rd;
            free_cnt_in  = free_cnt_ff - CB'(1);
            if (len_ff[qi] == '0) begin
               head_in[qi] = free_head_ff;
            end
            entry_in    = tail_ff[qi];
            tail_in[qi] = free_head_ff;
            len_in[qi]  = len_ff[qi] + CB'(1);
         end
         mqlb_pkg::OP_ENQ_LINK: begin
            link_we    = 1'b1;
            link_waddr = entry_ff;
            link_wdata = tail_ff[qi];
         end
         mqlb_pkg::OP_DEQ_RD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff[qi];
            entry_in = head_ff[qi];
         end
         mqlb_pkg::OP_DEQ_WR: begin
            head_in[qi]  = link_rd;
            link_we      = 1'b1;
            link_waddr   = entry_ff;
            link_wdata   = free_head_ff;
            free_head_in = entry_ff;
            if (32'(free_cnt_ff) < mqlb_pkg::POOL_ENTRIES) begin
               free_cnt_in = free_cnt_ff + CB'(1);
            end
            len_in[qi] = len_ff[qi] - CB'(1);
            if (len_ff[qi] == CB'(1)) begin
               head_in[qi] = '0;
               tail_in[qi] = '0;
            end
         end
         mqlb_pkg::OP_FLUSH, mqlb_pkg::OP_FLUSH_ALL: begin
            if (cmd.op == mqlb_pkg::OP_FLUSH_ALL) begin
               walk_in = walk_ff + WB'(1);
            end
            if (f_ok && (len_ff[fidx] != '0)) begin
               link_we      = 1'b1;
               link_waddr   = tail_ff[fidx];
               link_wdata   = free_head_ff;
               free_head_in = head_ff[fidx];
               free_cnt_in  = (32'(cnt_sum) > mqlb_pkg::POOL_ENTRIES) ?
                              CB'(mqlb_pkg::POOL_ENTRIES) : CB'(cnt_sum);
               len_in[fidx]  = '0;
               head_in[fidx] = '0;
               tail_in[fidx] = '0;
            end
         end
         mqlb_pkg::OP_LIST_START: begin
            rd_en   = 1'b1;
            rd_addr = head_ff[qi];
            walk_in = WB'(len_ff[qi]);
         end
         mqlb_pkg::OP_LIST_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = link_rd;
            walk_in = walk_ff - WB'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (cmd.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = cmd.status;
         rsp_in.last_result = cmd.last;
         case (cmd.sel)
            mqlb_pkg::EM_ENQ: begin
               rsp_in.out_receiver = req_ff.queue_index;
               rsp_in.out_sender   = req_ff.sender_id;
               rsp_in.out_handle   = 16'(HB'(req_ff.message_handle));
            end
            mqlb_pkg::EM_ENTRY: begin
               rsp_in.out_receiver = req_ff.queue_index;
               rsp_in.out_sender   = data_rd[mqlb_pkg::DATA_BITS-1 -: 4];
               rsp_in.out_handle   = 16'(data_rd[HB-1:0]);
            end
            default: begin
               rsp_in.out_receiver = '0;
               rsp_in.out_sender   = '0;
               rsp_in.out_handle   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff      <= mqlb_pkg::QUEUE_COUNT_RESET;
         free_head_ff <= '0;
         free_cnt_ff  <= CB'(mqlb_pkg::POOL_ENTRIES);
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NQ; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            len_ff[i]  <= '0;
         end
      end else begin
         qcnt_ff      <= qcnt_in;
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
      end
      req_ff   <= req_in;
      entry_ff <= entry_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/mqlb_controller.sv */
// ----------------------------------------------------------------------------
// Multi-queue linked buffer controller
// Sequences each command into datapath operations and result emission.
// ----------------------------------------------------------------------------
module mqlb_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mqlb_pkg::dp_stat_type stat,
   output mqlb_pkg::ctl_cmd_type cmd
);

   typedef enum logic [7:0] {
      S_INIT     = 8'b00000001,
      S_IDLE     = 8'b00000010,
      S_DECODE   = 8'b00000100,
      S_ENQ_WR   = 8'b00001000,
      S_ENQ_LINK = 8'b00010000,
      S_DEQ_WR   = 8'b00100000,
      S_FALL     = 8'b01000000,
      S_EMIT     = 8'b10000000
   } state_type;

   state_type              state_ff, state_in;
   mqlb_pkg::emit_sel_type em_sel_ff, em_sel_in;
   logic [1:0]             em_status_ff, em_status_in;
   logic                   em_list_ff, em_list_in;

   always_comb begin
      state_in     = state_ff;
      em_sel_in    = em_sel_ff;
      em_status_in = em_status_ff;
      em_list_in   = em_list_ff;
      cmd.op       = mqlb_pkg::OP_NONE;
      cmd.emit     = 1'b0;
      cmd.sel      = mqlb_pkg::EM_NONE;
      cmd.status   = mqlb_pkg::ST_OK;
      cmd.last     = 1'b1;
      case (state_ff)
         S_INIT: begin
            cmd.op = mqlb_pkg::OP_INIT;
            if (stat.walk_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = mqlb_pkg::OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in     = S_EMIT;
            em_sel_in    = mqlb_pkg::EM_NONE;
            em_status_in = mqlb_pkg::ST_OK;
            em_list_in   = 1'b0;
            case (stat.command)
               mqlb_pkg::CMD_ENQUEUE: begin
                  if (!stat.q_ok || stat.pool_empty) begin
                     em_status_in = mqlb_pkg::ST_FULL;
                  end else begin
                     cmd.op    = mqlb_pkg::OP_ENQ_RD;
                     em_sel_in = mqlb_pkg::EM_ENQ;
                     state_in  = S_ENQ_WR;
                  end
               end
               mqlb_pkg::CMD_DEQUEUE: begin
                  if (stat.q_empty) begin
                     em_status_in = mqlb_pkg::ST_EMPTY;
                  end else begin
                     cmd.op    = mqlb_pkg::OP_DEQ_RD;
                     em_sel_in = mqlb_pkg::EM_ENTRY;
                     state_in  = S_DEQ_WR;
                  end
               end
               mqlb_pkg::CMD_FLUSH: begin
                  cmd.op = mqlb_pkg::OP_FLUSH;
               end
               mqlb_pkg::CMD_PEEK: begin
                  if (stat.q_empty) begin
                     em_status_in = mqlb_pkg::ST_EMPTY;
                  end else begin
                     cmd.op    = mqlb_pkg::OP_DEQ_RD;
                     em_sel_in = mqlb_pkg::EM_ENTRY;
                  end
               end
               mqlb_pkg::CMD_LIST: begin
                  if (stat.q_empty) begin
                     em_status_in = mqlb_pkg::ST_EMPTY;
                  end else begin
                     cmd.op     = mqlb_pkg::OP_LIST_START;
                     em_sel_in  = mqlb_pkg::EM_ENTRY;
                     em_list_in = 1'b1;
                  end
               end
               mqlb_pkg::CMD_FLUSH_ALL: begin
                  state_in = S_FALL;
               end
               default: begin
               end
            endcase
         end
         S_ENQ_WR: begin
            cmd.op   = mqlb_pkg::OP_ENQ_WR;
            state_in = stat.q_empty ? S_EMIT : S_ENQ_LINK;
         end
         S_ENQ_LINK: begin
            cmd.op   = mqlb_pkg::OP_ENQ_LINK;
            state_in = S_EMIT;
         end
         S_DEQ_WR: begin
            cmd.op   = mqlb_pkg::OP_DEQ_WR;
            state_in = S_EMIT;
         end
         S_FALL: begin
            if (stat.fa_done) begin
               state_in = S_EMIT;
            end else begin
               cmd.op = mqlb_pkg::OP_FLUSH_ALL;
            end
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit   = 1'b1;
               cmd.sel    = em_sel_ff;
               cmd.status = em_status_ff;
               cmd.last   = !em_list_ff || stat.list_last;
               if (em_list_ff && !stat.list_last) begin
                  cmd.op = mqlb_pkg::OP_LIST_NEXT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
      em_sel_ff    <= em_sel_in;
      em_status_ff <= em_status_in;
      em_list_ff   <= em_list_in;
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Multi-queue linked buffer testbench
// Drives enqueue, dequeue, peek, list and flush transactions with random gaps
// and stalls, predicts every response with a behavioral queue model and
// compares each response with the prediction as a whole.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mqlb_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mqlb_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic [4:0]        csr_wdata = '0;

   multi_queue_linked_buffer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Behavioral model: each queue is a queue of {sender, handle}.
   logic [19:0]       queue_model[mqlb_pkg::NUM_QUEUES][$];
   int                used_entries;
   logic [4:0]        queue_count_model;
   mqlb_pkg::rsp_type expected_rsps[$];
   int                error_count;
   int                sent_count;
   int                rsp_count;
   int                cycle_count;
   int                stall_max;

   function automatic mqlb_pkg::rsp_type make_rsp(logic [1:0] st, logic [3:0] rcv,
                                                  logic [19:0] d, logic last);
      mqlb_pkg::rsp_type r;
      r.status = st;
      r.out_receiver = rcv;
      r.out_sender = d[19:16];
      r.out_handle = d[15:0];
      r.last_result = last;
      return r;
   endfunction

   function automatic void predict_transaction(mqlb_pkg::req_type t);
      logic [3:0] q;
      int n;
      q = t.queue_index;
      case (t.command)
         mqlb_pkg::CMD_ENQUEUE: begin
            if (used_entries >= mqlb_pkg::POOL_ENTRIES) begin
               expected_rsps.push_back(make_rsp(mqlb_pkg::ST_FULL, '0, '0, 1'b1));
            end else begin
               queue_model[q].push_back({t.sender_id, t.message_handle});
               used_entries++;
               expected_rsps.push_back(make_rsp(mqlb_pkg::ST_OK, q,
                  {t.sender_id, t.message_handle}, 1'b1));
            end
         end
         mqlb_pkg::CMD_DEQUEUE, mqlb_pkg::CMD_PEEK: begin
            if (queue_model[q].size() == 0) begin
               expected_rsps.push_back(make_rsp(mqlb_pkg::ST_EMPTY, '0, '0, 1'b1));
            end else begin
               expected_rsps.push_back(make_rsp(mqlb_pkg::ST_OK, q, queue_model[q][0],
                                                1'b1));
               if (t.command == mqlb_pkg::CMD_DEQUEUE) begin
                  void'(queue_model[q].pop_front());
                  used_entries--;
               end
            end
         end
         mqlb_pkg::CMD_FLUSH: begin
            used_entries -= queue_model[q].size();
            queue_model[q].delete();
            expected_rsps.push_back(make_rsp(mqlb_pkg::ST_OK, '0, '0, 1'b1));
         end
         mqlb_pkg::CMD_LIST: begin
            n = queue_model[q].size();
            if (n == 0)
               expected_rsps.push_back(make_rsp(mqlb_pkg::ST_EMPTY, '0, '0, 1'b1));
            for (int i = 0; i < n; i++)
               expected_rsps.push_back(make_rsp(mqlb_pkg::ST_OK, q, queue_model[q][i],
                                                i == n - 1));
         end
         mqlb_pkg::CMD_FLUSH_ALL: begin
            n = (queue_count_model > mqlb_pkg::NUM_QUEUES) ? mqlb_pkg::NUM_QUEUES :
                queue_count_model;
            for (int i = 0; i < n; i++) begin
               used_entries -= queue_model[i].size();
               queue_model[i].delete();
            end
            expected_rsps.push_back(make_rsp(mqlb_pkg::ST_OK, '0, '0, 1'b1));
         end
         default: expected_rsps.push_back(make_rsp(mqlb_pkg::ST_OK, '0, '0, 1'b1));
      endcase
   endfunction

   task automatic send_transaction(logic [2:0] cmd, logic [3:0] q, logic [3:0] snd,
                                   logic [15:0] h);
      mqlb_pkg::req_type t;
      int gap;
      t.command = cmd;
      t.queue_index = q;
      t.sender_id = snd;
      t.message_handle = h;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      predict_transaction(t);
      sent_count++;
   endtask

   task automatic send_random_transaction();
      logic [2:0] cmd;
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) cmd = mqlb_pkg::CMD_ENQUEUE;
      else if (r < 58) cmd = mqlb_pkg::CMD_DEQUEUE;
      else if (r < 70) cmd = mqlb_pkg::CMD_PEEK;
      else if (r < 82) cmd = mqlb_pkg::CMD_LIST;
      else if (r < 89) cmd = mqlb_pkg::CMD_FLUSH;
      else if (r < 93) cmd = mqlb_pkg::CMD_FLUSH_ALL;
      else cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
      send_transaction(cmd, ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) :
                       4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       16'($urandom_range(0, 65535)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_queue_count(logic [4:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      queue_count_model = value;
   endtask

   task automatic test_directed();
      send_transaction(mqlb_pkg::CMD_DEQUEUE, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_PEEK, 15, 0, 0);
      send_transaction(mqlb_pkg::CMD_LIST, 3, 0, 0);
      send_transaction(mqlb_pkg::CMD_ENQUEUE, 0, 4'hf, 16'hffff);
      send_transaction(mqlb_pkg::CMD_ENQUEUE, 0, 4'h0, 16'h0000);
      send_transaction(mqlb_pkg::CMD_ENQUEUE, 15, 4'ha, 16'h5a5a);
      send_transaction(mqlb_pkg::CMD_PEEK, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_LIST, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_DEQUEUE, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_FLUSH, 15, 0, 0);
      send_transaction(mqlb_pkg::CMD_FLUSH, 7, 0, 0);
      send_transaction(CMD_SPARE_A, 1, 2, 3);
      send_transaction(CMD_SPARE_B, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_FLUSH_ALL, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_LIST, 0, 0, 0);
   endtask

   task automatic test_pool_full();
      for (int i = 0; i < mqlb_pkg::POOL_ENTRIES + 3; i++)
         send_transaction(mqlb_pkg::CMD_ENQUEUE, 4'(i % 3), 4'($urandom_range(0, 15)),
                          16'($urandom_range(0, 65535)));
      send_transaction(mqlb_pkg::CMD_LIST, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_DEQUEUE, 1, 0, 0);
      send_transaction(mqlb_pkg::CMD_ENQUEUE, 5, 1, 16'h1234);
      send_transaction(mqlb_pkg::CMD_FLUSH_ALL, 0, 0, 0);
   endtask

   task automatic test_queue_count();
      write_queue_count(5'd0);
      send_transaction(mqlb_pkg::CMD_ENQUEUE, 0, 1, 1);
      send_transaction(mqlb_pkg::CMD_FLUSH_ALL, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_LIST, 0, 0, 0);
      write_queue_count(5'd1);
      send_transaction(mqlb_pkg::CMD_ENQUEUE, 1, 2, 2);
      send_transaction(mqlb_pkg::CMD_FLUSH_ALL, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_LIST, 0, 0, 0);
      send_transaction(mqlb_pkg::CMD_LIST, 1, 0, 0);
      write_queue_count(5'd31);
      send_transaction(mqlb_pkg::CMD_FLUSH_ALL, 0, 0, 0);
   endtask

   task automatic test_random();
      for (int i = 0; i < 62; i++) send_random_transaction();
      write_queue_count(5'($urandom_range(2, 8)));
      stall_max = 12;
      for (int i = 0; i < 62; i++) send_random_transaction();
      write_queue_count(5'd16);
   endtask

   // Response stall pattern: mostly ready, sometimes long stalls.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (stall_max == 0)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(0, 99) < 70) ||
                      ($urandom_range(0, stall_max) == 0);
   end

   always @(posedge clock) begin
      mqlb_pkg::rsp_type e;
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response %h", $time, rsp_data);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data !== e) begin
               error_count++;
               $display("%0t: mismatch expected %h actual %h", $time, e, rsp_data);
            end
         end
      end
      if (cycle_count > 400000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      sent_count = 0;
      rsp_count = 0;
      cycle_count = 0;
      stall_max = 3;
      used_entries = 0;
      queue_count_model = mqlb_pkg::QUEUE_COUNT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pool_full();
      test_queue_count();
      test_random();
      wait_idle();
      $display("Sent %0d transactions and checked %0d responses,", sent_count, rsp_count);
      $display("covering all commands, a full pool and several queue counts.");
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

/* multi_queue_linked_buffer.f */
hw/rtl/mqlb_pkg.sv
hw/rtl/mqlb_ram.sv
hw/rtl/mqlb_datapath.sv
hw/rtl/mqlb_controller.sv
hw/rtl/multi_queue_linked_buffer.sv
tb/testbench.sv
